### rtl/core/ghd_pkg.sv
// Shared types, constants and the static dictionary of the generic header decompressor.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ghd_pkg;

    localparam int ADDR_W = 8;
    localparam int DATA_W = 8;
    localparam int ACTION_W = 2;
    localparam int KIND_W = 2;
    localparam int PFX_W = 6;
    localparam int LIT_W = 7;
    localparam int RUN_W = 7;
    localparam int HIST_DEPTH = 256;

    // Default frame limits; the top level takes them as parameters.
    localparam int MAX_PAYLOAD = 127;
    localparam int MAX_RUN = 64;

    // Address prefix and history layout.
    localparam logic [PFX_W-1:0] PREFIX_LEN = 6'd32;
    localparam logic [ADDR_W-1:0] DICT_BASE = 8'd32;
    localparam logic [ADDR_W-1:0] DICT_LAST = 8'd47;
    localparam logic [ADDR_W-1:0] PAYLOAD_BASE = 8'd48;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_ADDR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STREAM = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EOF = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

    // Stream codes.
    localparam logic [7:0] CODE_STOP = 8'h90;
    localparam logic [3:0] TAG_ZERO_RUN = 4'h8;
    localparam logic [2:0] TAG_EXT_ARG = 3'h5;

    localparam logic [7:0] DICT_BYTES [16] = '{
        8'h16, 8'hfe, 8'hfd, 8'h17, 8'hfe, 8'hfd, 8'h00, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00
    };

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] byte_value;
        logic [KIND_W-1:0] kind;
        logic              last_of_run;
    } t_emit;

endpackage

### rtl/core/ghd_in_if.sv
// Input channel of the decompressor: valid/ready handshake carrying action and data byte.
// Depends on ghd_pkg for the field widths.
`timescale 1ns / 1ps

interface ghd_in_if;
    import ghd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

### rtl/core/ghd_out_if.sv
// Output channel of the decompressor: valid/ready handshake carrying one result word.
// Depends on ghd_pkg for the field widths.
`timescale 1ns / 1ps

interface ghd_out_if;
    import ghd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] byte_value;
    logic [KIND_W-1:0] kind;
    logic              last_of_run;

    modport source (output valid, output byte_value, output kind, output last_of_run,
                    input ready);
    modport sink (input valid, input byte_value, input kind, input last_of_run,
                  output ready);
endinterface

### rtl/core/ghd_hist.sv
// History store: 256 x 8 synchronous memory, one write and one registered read port.
// Depends on ghd_pkg for the request struct and the static dictionary.
`timescale 1ns / 1ps

module ghd_hist (
    input  logic              i_clk,
    input  ghd_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import ghd_pkg::*;

    logic [DATA_W-1:0] mem [HIST_DEPTH];
    logic [DATA_W-1:0] r_data;
    logic              r_dict_sel;
    logic [3:0]        r_dict_idx;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // The dictionary entries are never written by payload or address bytes, so
    // reads of that window are answered from the constant table instead of a copy.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_data     <= mem[i_req.raddr];
            r_dict_sel <= (i_req.raddr inside {[DICT_BASE:DICT_LAST]});
            r_dict_idx <= i_req.raddr[3:0];
        end
    end

    assign o_rdata = r_dict_sel ? DICT_BYTES[r_dict_idx] : r_data;

endmodule

### rtl/core/ghd_ctrl.sv
// Decoder control: frame state, code decoding and the copy/zero-run sequencer.
// Depends on ghd_pkg and ghd_in_if; drives the history store and the result stage.
`timescale 1ns / 1ps

module ghd_ctrl #(
    parameter int MAX_PAYLOAD = ghd_pkg::MAX_PAYLOAD,
    parameter int MAX_RUN     = ghd_pkg::MAX_RUN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ghd_in_if.sink            i_in,
    input  logic              i_slot_free,
    input  logic [7:0]        i_rdata,
    output ghd_pkg::t_mem_req o_mem_req,
    output ghd_pkg::t_emit    o_emit
);
    import ghd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [9:0] PAYLOAD_LIM = 10'(MAX_PAYLOAD);
    localparam logic [8:0] RUN_LIM     = 9'(MAX_RUN);

    logic              r_state, n_state;
    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [PFX_W-1:0]  r_pfx, n_pfx;
    logic [7:0]        r_sa, n_sa;
    logic [7:0]        r_na, n_na;
    logic [LIT_W-1:0]  r_lit, n_lit;
    logic              r_done, n_done;
    logic [RUN_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_src, n_src;
    logic              r_zero, n_zero;
    logic              r_pend, n_pend;

    logic              in_take;
    logic [7:0]        b;
    logic [7:0]        used;
    logic [4:0]        zero_len;
    logic [8:0]        bref_n;
    logic [9:0]        bref_s;
    logic [8:0]        ext_sa;
    logic [8:0]        ext_na;
    logic              pend_take;
    logic              issue;
    logic [DATA_W-1:0] run_byte;

    assign i_in.ready = (r_state == ST_IDLE) && i_slot_free;
    assign in_take    = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // Decoding only happens once the prefix is complete, so the pointer is at
    // least the payload base here.
    assign used     = r_wp - PAYLOAD_BASE;
    assign zero_len = {1'b0, b[3:0]} + 5'd2;
    assign bref_n   = {1'b0, r_na} + {6'b0, b[5:3]} + 9'd2;
    assign bref_s   = {2'b0, r_sa} + {7'b0, b[2:0]} + {1'b0, bref_n};
    assign ext_sa   = {1'b0, r_sa} + {2'b0, b[3:0], 3'b000};
    assign ext_na   = {1'b0, r_na} + {5'b0, b[4], 3'b000};

    // A byte is read through the registered read port ahead of its write-back. A new read is issued only
    // when the previous word leaves in the same cycle, and the distance is at least
    // two, so the read never targets the entry being written.
    assign pend_take = (r_state == ST_RUN) && r_pend && i_slot_free;
    assign issue     = (r_state == ST_RUN) && (r_cnt != '0) && (!r_pend || pend_take);
    assign run_byte  = r_zero ? '0 : i_rdata;

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_pfx     = r_pfx;
        n_sa      = r_sa;
        n_na      = r_na;
        n_lit     = r_lit;
        n_done    = r_done;
        n_cnt     = r_cnt;
        n_src     = r_src;
        n_zero    = r_zero;
        n_pend    = r_pend;
        o_mem_req = '0;
        o_emit    = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    case (i_in.action)
                        ACT_ADDR: begin
                            if (r_pfx < PREFIX_LEN) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = {2'b00, r_pfx};
                                o_mem_req.wdata = b;
                                n_pfx           = r_pfx + 1'b1;
                                if (r_pfx == PREFIX_LEN - 1'b1) begin
                                    n_wp = PAYLOAD_BASE;
                                end
                            end
                        end
                        ACT_STREAM: begin
                            if (r_pfx == PREFIX_LEN && !r_done) begin
                                o_emit.last_of_run = 1'b1;
                                if (r_lit != '0) begin
                                    n_lit = r_lit - 1'b1;
                                    if ({2'b00, used} >= PAYLOAD_LIM) begin
                                        o_emit.valid = 1'b1;
                                        o_emit.kind  = KIND_ERR;
                                        n_done       = 1'b1;
                                    end else begin
                                        o_mem_req.we      = 1'b1;
                                        o_mem_req.waddr   = r_wp;
                                        o_mem_req.wdata   = b;
                                        o_emit.valid      = 1'b1;
                                        o_emit.kind       = KIND_BYTE;
                                        o_emit.byte_value = b;
                                        n_wp              = r_wp + 1'b1;
                                    end
                                end else if (b == CODE_STOP) begin
                                    o_emit.valid = 1'b1;
                                    o_emit.kind  = KIND_END;
                                    n_done       = 1'b1;
                                end else if (!b[7]) begin
                                    n_lit = b[6:0];
                                end else if (b[7:4] == TAG_ZERO_RUN) begin
                                    if ({2'b00, used} + {5'b0, zero_len} > PAYLOAD_LIM) begin
                                        o_emit.valid = 1'b1;
                                        o_emit.kind  = KIND_ERR;
                                        n_done       = 1'b1;
                                    end else begin
                                        n_state = ST_RUN;
                                        n_cnt   = {2'b00, zero_len};
                                        n_zero  = 1'b1;
                                    end
                                end else if (b[7:5] == TAG_EXT_ARG) begin
                                    n_sa = ext_sa[8] ? 8'hff : ext_sa[7:0];
                                    n_na = ext_na[8] ? 8'hff : ext_na[7:0];
                                end else begin
                                    // Backreference.
                                    n_sa = '0;
                                    n_na = '0;
                                    if (bref_s > {2'b00, r_wp} || bref_n > RUN_LIM ||
                                        {2'b00, used} + {1'b0, bref_n} > PAYLOAD_LIM) begin
                                        o_emit.valid = 1'b1;
                                        o_emit.kind  = KIND_ERR;
                                        n_done       = 1'b1;
                                    end else begin
                                        n_state = ST_RUN;
                                        n_cnt   = bref_n[RUN_W-1:0];
                                        n_zero  = 1'b0;
                                        n_src   = r_wp - bref_s[7:0];
                                    end
                                end
                            end
                        end
                        ACT_EOF: begin
                            if (!r_done) begin
                                o_emit.valid       = 1'b1;
                                o_emit.kind        = KIND_END;
                                o_emit.last_of_run = 1'b1;
                            end
                            n_pfx  = '0;
                            n_sa   = '0;
                            n_na   = '0;
                            n_lit  = '0;
                            n_done = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (pend_take) begin
                    o_mem_req.we       = 1'b1;
                    o_mem_req.waddr    = r_wp;
                    o_mem_req.wdata    = run_byte;
                    o_emit.valid       = 1'b1;
                    o_emit.kind        = KIND_BYTE;
                    o_emit.byte_value  = run_byte;
                    o_emit.last_of_run = (r_cnt == '0);
                    n_wp               = r_wp + 1'b1;
                end
                if (issue) begin
                    o_mem_req.re    = !r_zero;
                    o_mem_req.raddr = r_src;
                    n_src           = r_src + 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                    n_pend          = 1'b1;
                end else if (pend_take) begin
                    n_pend = 1'b0;
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_pfx   <= '0;
            r_sa    <= '0;
            r_na    <= '0;
            r_lit   <= '0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_pfx   <= n_pfx;
            r_sa    <= n_sa;
            r_na    <= n_na;
            r_lit   <= n_lit;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_zero <= n_zero;
    end

endmodule

### rtl/core/generic_header_decompressor_unit.sv
// Top level of the generic header decompressor: control, history store, result register.
// Depends on ghd_pkg, ghd_in_if, ghd_out_if, ghd_ctrl and ghd_hist.
//
//   Channel  Dir  Fields                          Word accepted when
//   i_in     in   action, data_byte               i_in.valid && i_in.ready
//   o_out    out  byte_value, kind, last_of_run   o_out.valid && o_out.ready
//
// Address bytes, literal bytes, codes and end of frame are each decoded as they are accepted.
// A zero run or backreference of n bytes holds off the input while it streams its n
// words, one word per cycle unless the output stalls, paced by the single history read port.
// Reset is synchronous; no clearing pass, the history needs no initial contents.
// A stalled output word holds in the result register and stalls the sequencer.
`timescale 1ns / 1ps

module generic_header_decompressor_unit #(
    parameter int MAX_PAYLOAD = ghd_pkg::MAX_PAYLOAD,
    parameter int MAX_RUN     = ghd_pkg::MAX_RUN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ghd_in_if.sink     i_in,
    ghd_out_if.source  o_out
);
    import ghd_pkg::*;

    t_mem_req          mem_req;
    t_emit             emit;
    logic [DATA_W-1:0] rdata;
    logic              slot_free;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_byte;
    logic [KIND_W-1:0] r_out_kind;
    logic              r_out_last;

    assign slot_free = !r_out_valid || o_out.ready;

    ghd_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_RUN     (MAX_RUN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_slot_free (slot_free),
        .i_rdata     (rdata),
        .o_mem_req   (mem_req),
        .o_emit      (emit)
    );

    ghd_hist u_hist (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_out_byte <= emit.byte_value;
            r_out_kind <= emit.kind;
            r_out_last <= emit.last_of_run;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.byte_value  = r_out_byte;
    assign o_out.kind        = r_out_kind;
    assign o_out.last_of_run = r_out_last;

endmodule
